@@ sv/fbr_pkg.sv @@
// Shared types, widths, register codes and sine coefficients of the Fourier basis row generator.
package fbr_pkg;

  // Field widths
  localparam int unsigned PHASE_W = 16;
  localparam int unsigned COL_W   = 6;
  localparam int unsigned VAL_W   = 50;
  localparam int unsigned DEG_W   = 5;
  localparam int unsigned DORD_W  = 3;
  localparam int unsigned PWR_W   = 35;   // holds 31^7
  localparam int unsigned TRIG_W  = 16;   // -16384..16384
  localparam int unsigned MAG_W   = 15;   // 0..16384
  localparam int unsigned TDATA_W = 56;   // column + basis_value, whole bytes

  localparam int unsigned MAX_DEGREE_DEF = 31;

  // Configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  typedef enum logic {
    REG_DEGREE = 1'b0,
    REG_DERIV  = 1'b1
  } fbr_reg_e;

  // Constant column: 0.5 in Q1.14
  localparam logic [VAL_W-1:0] HALF_Q14 = VAL_W'(8192);
  localparam logic [MAG_W-1:0] QUARTER  = MAG_W'(16384);
  localparam logic [PHASE_W-1:0] COS_OFFSET = PHASE_W'(16384);

  // Item queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [DEG_W-1:0]   nharm;
    logic [DORD_W-1:0]  dord;
  } fbr_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fbr_qstat_t;

  // Quarter-wave sine: sin(pi/2 t) = t * sum (-1)^n b_n t^(2n),
  // b_n = (pi/2)^(2n+1) / (2n+1)!, all in Q62.
  localparam int unsigned NCOEF   = 12;
  localparam int unsigned CIDX_W  = 4;
  localparam int unsigned COEF_W  = 64;

  localparam logic [127:0] SC_0  = 128'h1921FB54442D1847 << 2;
  localparam logic [127:0] SC_U  = (SC_0 * SC_0) >> 62;
  localparam logic [127:0] SC_1  = ((SC_0  * SC_U) >> 62) / 6;
  localparam logic [127:0] SC_2  = ((SC_1  * SC_U) >> 62) / 20;
  localparam logic [127:0] SC_3  = ((SC_2  * SC_U) >> 62) / 42;
  localparam logic [127:0] SC_4  = ((SC_3  * SC_U) >> 62) / 72;
  localparam logic [127:0] SC_5  = ((SC_4  * SC_U) >> 62) / 110;
  localparam logic [127:0] SC_6  = ((SC_5  * SC_U) >> 62) / 156;
  localparam logic [127:0] SC_7  = ((SC_6  * SC_U) >> 62) / 210;
  localparam logic [127:0] SC_8  = ((SC_7  * SC_U) >> 62) / 272;
  localparam logic [127:0] SC_9  = ((SC_8  * SC_U) >> 62) / 342;
  localparam logic [127:0] SC_10 = ((SC_9  * SC_U) >> 62) / 420;
  localparam logic [127:0] SC_11 = ((SC_10 * SC_U) >> 62) / 506;

  localparam logic [COEF_W-1:0] SIN_COEF [NCOEF] = '{
    SC_0[63:0], SC_1[63:0], SC_2[63:0], SC_3[63:0], SC_4[63:0], SC_5[63:0],
    SC_6[63:0], SC_7[63:0], SC_8[63:0], SC_9[63:0], SC_10[63:0], SC_11[63:0]
  };

endpackage

@@ sv/fourier_basis_row_generator.sv @@
// Top level of the Fourier basis row generator: front, item queue and back part.
//
// Usage: write degree (address 0) and derivative_order (address 4) over the
// APB port while the block is idle. Each phase word accepted on s_axis yields
// one row on m_axis: column 0, then for k = 1..n the cos column k and the sin
// column n+k; tlast marks the final column. Degree zero gives one word of 0.
// m_axis_tdata: [5:0] column, [55:6] basis_value (signed).
// For each harmonic k the back part forms k^d by d multiplications by k, then
// gets the sine and then the cosine from the iterative sine unit (twelve series
// steps on a single 29x32 multiplier), then multiplies and loads each word.
// When idle, an accepted word passes the queue and the B_COL0 state into the
// output register, which then shows column 0. A two-entry queue lets the input
// side accept up to two words while a row is in progress. A stall on m_axis
// holds the output register; the back part waits only in its emit states,
// and the front keeps accepting until the queue is full.
// Reset clears both registers to zero, empties the queue and drops tvalid.
module fourier_basis_row_generator import fbr_pkg::*; #(
  parameter int unsigned MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  // Input words
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [PHASE_W-1:0] s_axis_tdata,   // [15:0] phase_x
  // Output words
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // [5:0] column, [55:6] basis_value
  output logic               m_axis_tlast
);

  logic       push;
  logic       pop;
  fbr_item_t  item_in;
  fbr_item_t  item_out;
  fbr_qstat_t qstat;

  assign pready = 1'b1;

  fbr_front #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .push_o    (push),
    .item_o    (item_in),
    .qstat_i   (qstat)
  );

  fbr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item_in),
    .pop_i   (pop),
    .item_o  (item_out),
    .qstat_o (qstat)
  );

  fbr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item_out),
    .qstat_i   (qstat),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

  // Never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && qstat.full))
    else $error("push into full item queue");

  // Never pop an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop && qstat.empty))
    else $error("pop from empty item queue");

  // A row that ends on column 0 is the degree-zero row and carries zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast && m_axis_tdata[COL_W-1:0] == '0)
      |-> (m_axis_tdata[TDATA_W-1:COL_W] == '0))
    else $error("degree-zero row with nonzero value");

  // The constant column is 0.5 or zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast && m_axis_tdata[COL_W-1:0] == '0)
      |-> (m_axis_tdata[TDATA_W-1:COL_W] == HALF_Q14 ||
           m_axis_tdata[TDATA_W-1:COL_W] == '0))
    else $error("bad constant column value");

endmodule

@@ sv/fbr_front.sv @@
// Front part: configuration registers and acceptance of phase words into the item queue.
module fbr_front import fbr_pkg::*; #(
  parameter int unsigned MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [APB_AW-1:0]  paddr_i,
  input  logic [APB_DW-1:0]  pwdata_i,
  output logic [APB_DW-1:0]  prdata_o,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  logic [PHASE_W-1:0] s_data_i,
  output logic               push_o,
  output fbr_item_t          item_o,
  input  fbr_qstat_t         qstat_i
);

  logic [DEG_W-1:0]  degree_q, degree_d;
  logic [DORD_W-1:0] dord_q, dord_d;
  logic              cfg_wr;
  fbr_reg_e          reg_sel;
  logic [DEG_W-1:0]  max_deg;
  logic [DEG_W-1:0]  nharm;

  assign cfg_wr  = psel_i & penable_i & pwrite_i;
  assign reg_sel = fbr_reg_e'(paddr_i[2]);

  // Register write decode
  always_comb begin
    degree_d = degree_q;
    dord_d   = dord_q;
    if (cfg_wr) begin
      case (reg_sel)
        REG_DEGREE: degree_d = pwdata_i[DEG_W-1:0];
        REG_DERIV:  dord_d   = pwdata_i[DORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= '0;
      dord_q   <= '0;
    end else begin
      degree_q <= degree_d;
      dord_q   <= dord_d;
    end
  end

  // Register read-back
  always_comb begin
    case (reg_sel)
      REG_DEGREE: prdata_o = APB_DW'(degree_q);
      REG_DERIV:  prdata_o = APB_DW'(dord_q);
      default:    prdata_o = '0;
    endcase
  end

  // Clamp the harmonic count
  assign max_deg = DEG_W'(MAX_DEGREE);
  assign nharm   = (degree_q > max_deg) ? max_deg : degree_q;

  // Accept a word whenever the queue has room
  assign s_ready_o    = ~qstat_i.full;
  assign push_o       = s_valid_i & ~qstat_i.full;
  assign item_o.phase = s_data_i;
  assign item_o.nharm = nharm;
  assign item_o.dord  = dord_q;

endmodule

@@ sv/fbr_queue.sv @@
// Short item queue between the front and back parts.
module fbr_queue import fbr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  fbr_item_t  item_i,
  input  logic       pop_i,
  output fbr_item_t  item_o,
  output fbr_qstat_t qstat_o
);

  fbr_item_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  cnt_q;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  assign item_o        = mem_q[rd_ptr_q];
  assign qstat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign qstat_o.empty = (cnt_q == '0);

endmodule

@@ sv/fbr_trig.sv @@
// Iterative sine unit: round(16384*sin(pi*p/32768)) by a Horner series on one multiplier.
module fbr_trig import fbr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [PHASE_W-1:0]       phase_i,
  output logic                     done_o,
  output logic signed [TRIG_W-1:0] value_o
);

  typedef enum logic [1:0] {
    T_IDLE = 2'b01,
    T_RUN  = 2'b10
  } trig_state_e;

  trig_state_e       state_q, state_d;
  logic [MAG_W-1:0]  r_q;
  logic [28:0]       r2_q;
  logic              neg_q;
  logic [COEF_W-1:0] p_q;
  logic [CIDX_W-1:0] idx_q;
  logic [1:0]        ph_q;
  logic [60:0]       lo_q, hi_q;
  logic signed [TRIG_W-1:0] val_q;
  logic              done_q;

  logic [MAG_W-1:0]  r_in;
  logic              fin;
  logic [28:0]       mul_a;
  logic [31:0]       mul_b;
  logic [60:0]       prod;
  logic [92:0]       sum;
  logic [92:0]       rsum;
  logic [MAG_W-1:0]  mag;
  logic [CIDX_W-1:0] idx_m1;

  // Fold the phase into the first quadrant
  always_comb begin
    if (phase_i[14]) begin
      r_in = QUARTER - {1'b0, phase_i[13:0]};
    end else begin
      r_in = {1'b0, phase_i[13:0]};
    end
  end

  // Shared multiplier: r^2 for Horner steps, r for the final scale
  assign fin    = (idx_q == '0);
  assign mul_a  = fin ? 29'(r_q) : r2_q;
  assign mul_b  = (ph_q == 2'd0) ? p_q[31:0] : p_q[63:32];
  assign prod   = mul_a * mul_b;
  assign sum    = {hi_q, 32'b0} + 93'(lo_q);
  assign rsum   = sum + (93'(1) << 61);
  assign mag    = rsum[76:62];
  assign idx_m1 = idx_q - CIDX_W'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      T_IDLE:  if (start_i) state_d = T_RUN;
      T_RUN:   if (ph_q == 2'd2 && fin) state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      done_q  <= 1'b0;
      ph_q    <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      case (state_q)
        T_IDLE: begin
          if (start_i) begin
            ph_q  <= '0;
            idx_q <= CIDX_W'(NCOEF - 1);
          end
        end
        T_RUN: begin
          if (ph_q == 2'd2) begin
            ph_q <= '0;
            if (fin) begin
              done_q <= 1'b1;
            end else begin
              idx_q <= idx_m1;
            end
          end else begin
            ph_q <= ph_q + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath: load operands, step the series, round the result
  always_ff @(posedge clk_i) begin
    if (state_q == T_IDLE && start_i) begin
      r_q   <= r_in;
      r2_q  <= 29'(r_in * r_in);
      neg_q <= phase_i[15];
      p_q   <= SIN_COEF[NCOEF-1];
    end else if (state_q == T_RUN) begin
      case (ph_q)
        2'd0: lo_q <= prod;
        2'd1: hi_q <= prod;
        2'd2: begin
          if (fin) begin
            val_q <= neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
          end else begin
            p_q <= SIN_COEF[idx_m1] - sum[91:28];
          end
        end
        default: ;
      endcase
    end
  end

  assign done_o  = done_q;
  assign value_o = val_q;

endmodule

@@ sv/fbr_back.sv @@
// Back part: walks the columns of one row, forms k^d times the trig value, drives the output word.
module fbr_back import fbr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fbr_item_t          item_i,
  input  fbr_qstat_t         qstat_i,
  output logic               pop_o,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output logic [TDATA_W-1:0] m_data_o,
  output logic               m_last_o
);

  typedef enum logic [8:0] {
    B_IDLE = 9'b000000001,
    B_COL0 = 9'b000000010,
    B_POW  = 9'b000000100,
    B_SIN  = 9'b000001000,
    B_COS  = 9'b000010000,
    B_MULC = 9'b000100000,
    B_EMC  = 9'b001000000,
    B_MULS = 9'b010000000,
    B_EMS  = 9'b100000000
  } back_state_e;

  back_state_e       state_q, state_d;
  logic [PHASE_W-1:0] x_q, hp_q;
  logic [DEG_W-1:0]  n_q, k_q;
  logic [DORD_W-1:0] d_q, i_q;
  logic [PWR_W-1:0]  pw_q;
  logic signed [TRIG_W-1:0] s_q, c_q;
  logic [VAL_W-1:0]  prod_q;

  logic               tvalid_q;
  logic [COL_W-1:0]   col_q;
  logic [VAL_W-1:0]   val_q;
  logic               last_q;

  logic               out_free;
  logic               trig_start;
  logic [PHASE_W-1:0] trig_phase;
  logic               trig_done;
  logic signed [TRIG_W-1:0] trig_val;

  logic                     is_cos;
  logic                     op_neg;
  logic signed [TRIG_W-1:0] op_sel;
  logic signed [16:0]       op;
  logic signed [52:0]       prod;
  logic [39:0]              pw_next;
  logic                     load;
  logic [COL_W-1:0]         load_col;
  logic [VAL_W-1:0]         load_val;
  logic                     load_last;

  fbr_trig u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (trig_start),
    .phase_i (trig_phase),
    .done_o  (trig_done),
    .value_o (trig_val)
  );

  assign out_free = ~tvalid_q | m_ready_i;

  // Pick operand and sign for the derivative pattern
  assign is_cos = (state_q == B_MULC);
  always_comb begin
    if (is_cos) begin
      op_sel = d_q[0] ? s_q : c_q;
      op_neg = d_q[0] ^ d_q[1];
    end else begin
      op_sel = d_q[0] ? c_q : s_q;
      op_neg = d_q[1];
    end
    op = op_neg ? -$signed({op_sel[TRIG_W-1], op_sel})
                :  $signed({op_sel[TRIG_W-1], op_sel});
  end

  assign prod    = $signed({1'b0, pw_q}) * op;
  assign pw_next = pw_q * k_q;

  // Trig requests: sine after the power is ready, cosine when sine returns
  always_comb begin
    trig_start = 1'b0;
    trig_phase = hp_q;
    if (state_q == B_POW && i_q == d_q) begin
      trig_start = 1'b1;
    end else if (state_q == B_SIN && trig_done) begin
      trig_start = 1'b1;
      trig_phase = hp_q + COS_OFFSET;
    end
  end

  // Output word selection
  always_comb begin
    load      = 1'b0;
    load_col  = '0;
    load_val  = '0;
    load_last = 1'b0;
    case (state_q)
      B_COL0: begin
        load      = out_free;
        load_val  = (n_q != '0 && d_q == '0) ? HALF_Q14 : '0;
        load_last = (n_q == '0);
      end
      B_EMC: begin
        load     = out_free;
        load_col = COL_W'(k_q);
        load_val = prod_q;
      end
      B_EMS: begin
        load      = out_free;
        load_col  = COL_W'(k_q) + COL_W'(n_q);
        load_val  = prod_q;
        load_last = (k_q == n_q);
      end
      default: ;
    endcase
  end

  assign pop_o = (state_q == B_IDLE) & ~qstat_i.empty;

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (!qstat_i.empty) state_d = B_COL0;
      B_COL0: if (out_free) state_d = (n_q == '0) ? B_IDLE : B_POW;
      B_POW:  if (i_q == d_q) state_d = B_SIN;
      B_SIN:  if (trig_done) state_d = B_COS;
      B_COS:  if (trig_done) state_d = B_MULC;
      B_MULC: state_d = B_EMC;
      B_EMC:  if (out_free) state_d = B_MULS;
      B_MULS: state_d = B_EMS;
      B_EMS:  if (out_free) state_d = (k_q == n_q) ? B_IDLE : B_POW;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        tvalid_q <= 1'b1;
      end else if (m_ready_i) begin
        tvalid_q <= 1'b0;
      end
    end
  end

  // Row and harmonic datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (!qstat_i.empty) begin
          x_q <= item_i.phase;
          n_q <= item_i.nharm;
          d_q <= item_i.dord;
        end
      end
      B_COL0: begin
        k_q  <= DEG_W'(1);
        hp_q <= x_q;
        pw_q <= PWR_W'(1);
        i_q  <= '0;
      end
      B_POW: begin
        if (i_q != d_q) begin
          pw_q <= pw_next[PWR_W-1:0];
          i_q  <= i_q + DORD_W'(1);
        end
      end
      B_SIN:  if (trig_done) s_q <= trig_val;
      B_COS:  if (trig_done) c_q <= trig_val;
      B_MULC: prod_q <= prod[VAL_W-1:0];
      B_MULS: prod_q <= prod[VAL_W-1:0];
      B_EMS: begin
        if (out_free) begin
          k_q  <= k_q + DEG_W'(1);
          hp_q <= hp_q + x_q;
          pw_q <= PWR_W'(1);
          i_q  <= '0;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      col_q  <= load_col;
      val_q  <= load_val;
      last_q <= load_last;
    end
  end

  assign m_valid_o = tvalid_q;
  assign m_data_o  = {val_q, col_q};
  assign m_last_o  = last_q;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the Fourier basis row generator: scoreboard, drivers and test phases.
`timescale 1ns / 100ps

module testbench;
  import fbr_pkg::*;

  // pi/2 in Q60, the base of the series evaluation
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SOURCE,
    IDLE_SINK,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] val;
    logic             last;
  } basis_word_t;

  // Predicts each row from the register copy and checks the output words in order.
  class basis_row_scoreboard;
    logic [DEG_W-1:0]  degree;
    logic [DORD_W-1:0] order;
    basis_word_t       pending [$];
    int unsigned       errors;
    int unsigned       phases_seen;
    int unsigned       words_seen;

    function new();
      degree      = '0;
      order       = '0;
      errors      = 0;
      phases_seen = 0;
      words_seen  = 0;
    endfunction

    // Keep only the bits each register holds
    function void set_register(fbr_reg_e idx, logic [31:0] value);
      if (idx == REG_DEGREE) degree = value[DEG_W-1:0];
      else order = value[DORD_W-1:0];
    endfunction

    // Truncating Q60 product
    function logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[123:60];
    endfunction

    // First-quadrant sine, rounded half up to Q14
    function longint quarter_sine(int unsigned r);
      logic [63:0]        ang;
      logic [63:0]        ang2;
      logic [63:0]        term;
      logic signed [63:0] acc;
      ang  = (HALF_PI_Q60 >> 14) * 64'(r) + (((HALF_PI_Q60 & 64'h3FFF) * 64'(r)) >> 14);
      ang2 = q60_mul(ang, ang);
      term = ang;
      acc  = $signed(ang);
      for (int j = 1; j <= 25; j++) begin
        term = q60_mul(term, ang2) / 64'((2 * j) * (2 * j + 1));
        if (j % 2 == 1) acc = acc - $signed(term);
        else acc = acc + $signed(term);
      end
      if (acc < 0) acc = 0;
      return longint'((64'(acc) + (64'd1 << 45)) >> 46);
    endfunction

    // Full-circle sine from quadrant folding
    function longint sine_q14(logic [PHASE_W-1:0] p);
      logic [1:0]  quad;
      int unsigned r;
      longint      mag;
      quad = p[15:14];
      r    = p[13:0];
      if (quad[0]) r = 16384 - r;
      mag = quarter_sine(r);
      return quad[1] ? -mag : mag;
    endfunction

    // Build the expected row for one accepted phase word
    function void note_phase(logic [PHASE_W-1:0] x);
      int unsigned        n;
      int unsigned        d;
      logic [PHASE_W-1:0] p;
      longint             pw;
      longint             sn;
      longint             cs;
      longint             cv;
      longint             sv;
      n = degree;
      d = order;
      phases_seen++;
      if (n == 0) begin
        pending.push_back('{col: '0, val: '0, last: 1'b1});
        return;
      end
      // constant column is one half only for the plain basis
      pending.push_back('{col: '0, val: (d == 0) ? VAL_W'(8192) : VAL_W'(0), last: 1'b0});
      for (int k = 1; k <= n; k++) begin
        p  = PHASE_W'(k * x);
        sn = sine_q14(p);
        cs = sine_q14(PHASE_W'(p + 16'h4000));
        pw = 1;
        for (int i = 0; i < d; i++) pw = pw * k;
        // derivative turns the pair by a quarter per order
        case (order[1:0])
          2'd0: begin cv =  pw * cs; sv =  pw * sn; end
          2'd1: begin cv = -pw * sn; sv =  pw * cs; end
          2'd2: begin cv = -pw * cs; sv = -pw * sn; end
          default: begin cv = pw * sn; sv = -pw * cs; end
        endcase
        pending.push_back('{col: COL_W'(k), val: VAL_W'(cv), last: 1'b0});
        pending.push_back('{col: COL_W'(k + n), val: VAL_W'(sv), last: (k == n)});
      end
    endfunction

    function void report(string what, longint want, longint got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    // Compare one output word with the oldest expectation
    function void check_word(logic [COL_W-1:0] col, logic [VAL_W-1:0] val, logic last);
      basis_word_t want;
      words_seen++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual column %0d value %0d last %0b",
                 $time, col, $signed(val), last);
        return;
      end
      want = pending.pop_front();
      if (col !== want.col) report("column", want.col, col);
      if (val !== want.val) report("basis_value", $signed(want.val), $signed(val));
      if (last !== want.last) report("tlast", want.last, last);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [PHASE_W-1:0] s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tlast;

  int unsigned          src_idle_pct;
  int unsigned          sink_stall_pct;
  basis_row_scoreboard  rowsb;

  fourier_basis_row_generator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Stall the output side at random
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Check every accepted output word
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      rowsb.check_word(m_axis_tdata[5:0], m_axis_tdata[55:6], m_axis_tlast);
  end

  // Hand one phase word over, with random gaps before it
  task automatic send_phase(input logic [PHASE_W-1:0] x);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    rowsb.note_phase(x);
    @(negedge clk_i);
  endtask

  // Write a register, then read it back
  task automatic write_register(input fbr_reg_e idx, input logic [31:0] value);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rowsb.set_register(idx, value);
    want = (idx == REG_DEGREE) ? 32'(value[DEG_W-1:0]) : 32'(value[DORD_W-1:0]);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want) begin
      rowsb.errors++;
      $display("%0t: register %0d readback mismatch, expected %0d, actual %0d",
               $time, idx, want, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Let the block run dry
  task automatic wait_rows_drained();
    while (rowsb.pending.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Drain, pick the idling style, then load both registers with junk in the upper bits
  task automatic apply_setting(input int unsigned deg, input int unsigned ord,
                               input idle_mode_e mode);
    s_axis_tvalid <= 1'b0;
    wait_rows_drained();
    case (mode)
      IDLE_NONE:   begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      IDLE_SOURCE: begin src_idle_pct = 81; sink_stall_pct = 0;  end
      IDLE_SINK:   begin src_idle_pct = 0;  sink_stall_pct = 81; end
      default:     begin src_idle_pct = 28; sink_stall_pct = 28; end
    endcase
    write_register(REG_DEGREE, ($urandom() << DEG_W) | deg);
    write_register(REG_DERIV, ($urandom() << DORD_W) | ord);
  endtask

  // Mostly uniform phases, with sixteenth-circle points (quadrant points among them) and the two ends mixed in
  function automatic logic [PHASE_W-1:0] pick_phase();
    case ($urandom_range(9))
      0:       return PHASE_W'($urandom_range(15) << 12);
      1:       return $urandom_range(1) ? 16'h0000 : 16'hFFFF;
      default: return PHASE_W'($urandom());
    endcase
  endfunction

  initial begin
    int unsigned deg;
    int unsigned ord;
    int unsigned count;
    int unsigned seg;
    rowsb          = new();
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Registers straight out of reset: degree zero
    send_phase(16'h0000);
    send_phase(16'hFFFF);

    // Degree zero ignores the derivative order
    apply_setting(0, 5, IDLE_NONE);
    send_phase(16'h8000);

    // Single harmonic at the quadrant points and both ends
    apply_setting(1, 0, IDLE_NONE);
    send_phase(16'h0000);
    send_phase(16'h0001);
    send_phase(16'h4000);
    send_phase(16'h8000);
    send_phase(16'hC000);
    send_phase(16'hFFFF);

    // Largest magnitudes: full degree, highest order
    apply_setting(31, 7, IDLE_NONE);
    send_phase(16'h0000);
    send_phase(16'h0001);
    apply_setting(31, 0, IDLE_NONE);
    send_phase(16'h5555);

    // Each remaining derivative order
    for (int o = 1; o <= 6; o++) begin
      apply_setting(3, o, IDLE_NONE);
      send_phase(pick_phase());
    end

    // Random phases over random settings; large degrees kept rare since rows get long
    seg = 0;
    while (rowsb.phases_seen < 460) begin
      case ($urandom_range(19))
        0, 1, 2: deg = $urandom_range(20, 31);
        3, 4:    deg = 0;
        default: deg = $urandom_range(1, 6);
      endcase
      ord = $urandom_range(7);
      apply_setting(deg, ord, idle_mode_e'(seg % 4));
      count = (deg >= 20) ? 4 : $urandom_range(10, 24);
      repeat (count) send_phase(pick_phase());
      seg++;
    end

    s_axis_tvalid <= 1'b0;
    wait_rows_drained();
    repeat (100) @(negedge clk_i);

    $display("covered %0d phase words and %0d row words over %0d register settings",
             rowsb.phases_seen, rowsb.words_seen, seg + 11);
    $display("degrees 0..31, derivative orders 0..7, idling on neither, either and both sides");
    if (rowsb.errors == 0 && rowsb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #150_000_000;
    $display("%0t: run timed out with %0d words outstanding", $time, rowsb.pending.size());
    $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
sv/fbr_pkg.sv
sv/fbr_front.sv
sv/fbr_queue.sv
sv/fbr_trig.sv
sv/fbr_back.sv
sv/fourier_basis_row_generator.sv
tb/sv/testbench.sv
